/* hw/rtl/ppmp6_pkg.sv */
// Types, character codes and result layout for the P6 stream parser.
// No dependencies; imported by ppm_p6_stream_parser_core.
`default_nettype none

package ppmp6_pkg;

	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 64;
	localparam int M_TUSER_W = 3;

	localparam int ACC_W = 17;
	localparam logic [ACC_W-1:0] ACC_CAP    = 17'h1_0000;
	localparam logic [ACC_W-1:0] REQ_MAXVAL = 17'd255;

	localparam logic [7:0] CH_COMMENT = 8'h23;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_P       = 8'h50;
	localparam logic [7:0] CH_6       = 8'h36;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;

	localparam logic [1:0] MAGIC_NONE = 2'd0;
	localparam logic [1:0] MAGIC_P    = 2'd1;
	localparam logic [1:0] MAGIC_P6   = 2'd2;

	localparam logic [1:0] CHAN_BLUE = 2'd2;

	typedef enum logic [6:0] {
		PH_MAGIC  = 7'b000_0001,
		PH_WIDTH  = 7'b000_0010,
		PH_HEIGHT = 7'b000_0100,
		PH_MAXVAL = 7'b000_1000,
		PH_PIXELS = 7'b001_0000,
		PH_DONE   = 7'b010_0000,
		PH_ERROR  = 7'b100_0000
	} phase_t;

	typedef enum logic [2:0] {
		KIND_HEADER   = 3'd0,
		KIND_PIXEL    = 3'd1,
		KIND_ERROR    = 3'd2,
		KIND_IGNORED  = 3'd3,
		KIND_COMPLETE = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ERR_NONE           = 4'd0,
		ERR_MAGIC          = 4'd1,
		ERR_WIDTH_MISSING  = 4'd2,
		ERR_WIDTH_INVALID  = 4'd3,
		ERR_HEIGHT_MISSING = 4'd4,
		ERR_HEIGHT_INVALID = 4'd5,
		ERR_MAXVAL_MISSING = 4'd6,
		ERR_MAXVAL_INVALID = 4'd7,
		ERR_MAXVAL_NOT_255 = 4'd8,
		ERR_TOO_LARGE      = 4'd9,
		ERR_TRUNCATED      = 4'd10
	} err_t;

	typedef struct packed {
		logic             started;
		logic             bad;
		logic [1:0]       prog;
		logic [ACC_W-1:0] acc;
	} token_t;

	typedef struct packed {
		err_t   err;
		phase_t ph;
		logic   wr_width;
		logic   wr_height;
		logic   done;
	} end_res_t;

	// error_code sits in the lowest bits of tdata
	typedef struct packed {
		logic [12:0] image_height;
		logic [12:0] image_width;
		logic [1:0]  color_channel;
		logic [11:0] pixel_row;
		logic [11:0] pixel_col;
		logic [7:0]  pixel_value;
		err_t        error_code;
	} res_data_t;

	typedef struct packed {
		kind_t     kind;
		logic      final_pixel;
		res_data_t data;
	} result_t;

endpackage

`default_nettype wire

/* hw/rtl/ppm_p6_stream_parser_core.sv */
// Binary PPM (P6) stream parser: header tokenizer, pixel indexer, result buffer.
// Depends on ppmp6_pkg.
//
//   channel  | dir | fields
//   s_axis   | in  | tdata: data_byte; tuser: first_byte; tlast: last_byte
//   m_axis   | out | tdata: error_code .. image_height; tuser: kind; tlast: final_pixel
//
// One request per cycle while the skid entry is empty; input stage, then result buffer.
// The parse state loop (phase, token, counters) closes with no register but its own.
// arst_n clears parse state and both buffer stages; no clearing pass.
// A two-entry output buffer keeps s_axis_tready free of any path from m_axis_tready.
`default_nettype none

module ppm_p6_stream_parser_core #(
	parameter int MAX_WIDTH  = ppmp6_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ppmp6_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [ppmp6_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [7:0] data_byte
	input  logic                            s_axis_tuser,  // [0] first_byte
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [3:0] error_code, [11:4] pixel_value, [23:12] pixel_col, [35:24] pixel_row,
	// [37:36] color_channel, [50:38] image_width, [63:51] image_height
	output logic [ppmp6_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic [ppmp6_pkg::M_TUSER_W-1:0] m_axis_tuser,  // [2:0] kind
	output logic                            m_axis_tlast
);

	import ppmp6_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam logic [ACC_W-1:0] MAX_W_A = ACC_W'(MAX_WIDTH);
	localparam logic [ACC_W-1:0] MAX_H_A = ACC_W'(MAX_HEIGHT);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;
	logic       last_s1;
	logic       adv;

	phase_t           phase_q;
	logic             cmt_q;
	token_t           tok_q;
	logic [ACC_W-1:0] width_q;
	logic [ACC_W-1:0] height_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic [1:0]       chn_q;
	err_t             sticky_q;

	phase_t           ph_c, ph_n;
	logic             cmt_c, cmt_n;
	token_t           tok_c, tok_a, tok_n;
	logic [ACC_W-1:0] w_c, w_n, h_c, h_n;
	logic [CW-1:0]    col_c, col_n;
	logic [RW-1:0]    row_c, row_n;
	logic [1:0]       chn_c, chn_n;
	err_t             sticky_c, sticky_n;
	end_res_t         end_r;
	logic             ends;
	logic             is_final;
	err_t             err;
	result_t          res;

	logic    m_valid_q;
	result_t m_res_q;
	logic    skid_valid_q;
	result_t skid_res_q;
	logic    pop;

	function automatic logic is_space(logic [7:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

	function automatic token_t add_char(phase_t ph, token_t tok, logic [7:0] b);
		token_t           r;
		logic [ACC_W+3:0] v;
		r = tok;
		r.started = 1'b1;
		v = '0;
		if (!tok.bad) begin
			if (ph == PH_MAGIC) begin
				if ((tok.prog == MAGIC_NONE) && (b == CH_P)) begin
					r.prog = MAGIC_P;
				end else if ((tok.prog == MAGIC_P) && (b == CH_6)) begin
					r.prog = MAGIC_P6;
				end else begin
					r.bad = 1'b1;
				end
			end else if ((b >= CH_0) && (b <= CH_9)) begin
				v = {1'b0, tok.acc, 3'b000} + {3'b000, tok.acc, 1'b0} + (ACC_W+4)'(b[3:0]);
				r.acc = (v > (ACC_W+4)'(ACC_CAP)) ? ACC_CAP : v[ACC_W-1:0];
			end else begin
				r.bad = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic end_res_t end_token(phase_t ph, token_t tok,
			logic [ACC_W-1:0] w, logic [ACC_W-1:0] h);
		end_res_t r;
		logic     num_ok;
		r.err = ERR_NONE;
		r.ph = ph;
		r.wr_width = 1'b0;
		r.wr_height = 1'b0;
		r.done = 1'b0;
		num_ok = tok.started && !tok.bad && (tok.acc != '0);
		unique case (ph)
			PH_MAGIC: begin
				if (tok.started && !tok.bad && (tok.prog == MAGIC_P6)) begin
					r.ph = PH_WIDTH;
				end else begin
					r.err = ERR_MAGIC;
				end
			end
			PH_WIDTH: begin
				priority if (!tok.started) begin
					r.err = ERR_WIDTH_MISSING;
				end else if (!num_ok) begin
					r.err = ERR_WIDTH_INVALID;
				end else begin
					r.wr_width = 1'b1;
					r.ph = PH_HEIGHT;
				end
			end
			PH_HEIGHT: begin
				priority if (!tok.started) begin
					r.err = ERR_HEIGHT_MISSING;
				end else if (!num_ok) begin
					r.err = ERR_HEIGHT_INVALID;
				end else begin
					r.wr_height = 1'b1;
					r.ph = PH_MAXVAL;
				end
			end
			default: begin
				priority if (!tok.started) begin
					r.err = ERR_MAXVAL_MISSING;
				end else if (!num_ok) begin
					r.err = ERR_MAXVAL_INVALID;
				end else if (tok.acc != REQ_MAXVAL) begin
					r.err = ERR_MAXVAL_NOT_255;
				end else if ((w > MAX_W_A) || (h > MAX_H_A)) begin
					r.err = ERR_TOO_LARGE;
				end else begin
					r.ph = PH_PIXELS;
					r.done = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	// input stage
	assign s_axis_tready = !valid_s1 || !skid_valid_q;
	assign adv = valid_s1 && !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			first_s1 <= s_axis_tuser;
			last_s1  <= s_axis_tlast;
		end
	end

	// parse one byte
	always_comb begin
		ph_c     = first_s1 ? PH_MAGIC : phase_q;
		cmt_c    = first_s1 ? 1'b0 : cmt_q;
		tok_c    = first_s1 ? '0 : tok_q;
		w_c      = first_s1 ? '0 : width_q;
		h_c      = first_s1 ? '0 : height_q;
		col_c    = first_s1 ? '0 : col_q;
		row_c    = first_s1 ? '0 : row_q;
		chn_c    = first_s1 ? '0 : chn_q;
		sticky_c = first_s1 ? ERR_NONE : sticky_q;

		ph_n     = ph_c;
		cmt_n    = cmt_c;
		tok_a    = tok_c;
		tok_n    = tok_c;
		w_n      = w_c;
		h_n      = h_c;
		col_n    = col_c;
		row_n    = row_c;
		chn_n    = chn_c;
		sticky_n = sticky_c;
		end_r    = '0;
		ends     = 1'b0;
		is_final = 1'b0;
		err      = ERR_NONE;
		res      = '0;
		res.kind = KIND_HEADER;

		unique case (ph_c)
			PH_ERROR: begin
				res.kind = KIND_ERROR;
				err = sticky_c;
			end
			PH_DONE: begin
				res.kind = KIND_IGNORED;
			end
			PH_PIXELS: begin
				if (cmt_c) begin
					if (byte_s1 == CH_LF) begin
						cmt_n = 1'b0;
					end
					if (last_s1) begin
						err = ERR_TRUNCATED;
					end
				end else begin
					is_final = (ACC_W'(col_c) + 1'b1 == w_c) && (ACC_W'(row_c) + 1'b1 == h_c)
						&& (chn_c == CHAN_BLUE);
					if (last_s1 && !is_final) begin
						err = ERR_TRUNCATED;
					end else begin
						res.kind = KIND_PIXEL;
						res.data.pixel_value = byte_s1;
						res.data.pixel_col = 12'(col_c);
						res.data.pixel_row = 12'(row_c);
						res.data.color_channel = chn_c;
						res.final_pixel = is_final;
						if (is_final) begin
							ph_n = PH_DONE;
						end else if (chn_c == CHAN_BLUE) begin
							chn_n = '0;
							if (ACC_W'(col_c) + 1'b1 >= w_c) begin
								col_n = '0;
								row_n = row_c + RW'(1);
							end else begin
								col_n = col_c + CW'(1);
							end
						end else begin
							chn_n = chn_c + 2'd1;
						end
					end
				end
			end
			default: begin
				if (cmt_c) begin
					if (byte_s1 == CH_LF) begin
						cmt_n = 1'b0;
					end
				end else if (!tok_c.started) begin
					if (byte_s1 == CH_COMMENT) begin
						cmt_n = 1'b1;
					end else if (!is_space(byte_s1)) begin
						tok_a = add_char(ph_c, tok_c, byte_s1);
					end
				end else if (is_space(byte_s1)) begin
					ends = 1'b1;
				end else if (byte_s1 == CH_COMMENT) begin
					cmt_n = 1'b1;
					ends = 1'b1;
				end else begin
					tok_a = add_char(ph_c, tok_c, byte_s1);
				end
				tok_n = tok_a;
				if (ends || last_s1) begin
					end_r = end_token(ph_c, tok_a, w_c, h_c);
					tok_n = '0;
					ph_n = end_r.ph;
					if (end_r.wr_width) begin
						w_n = tok_a.acc;
					end
					if (end_r.wr_height) begin
						h_n = tok_a.acc;
					end
					if (end_r.done) begin
						res.kind = KIND_COMPLETE;
						col_n = '0;
						row_n = '0;
						chn_n = '0;
					end
					priority if (end_r.err != ERR_NONE) begin
						err = end_r.err;
					end else if (last_s1) begin
						priority if (end_r.ph == PH_PIXELS) begin
							err = ERR_TRUNCATED;
						end else if (end_r.ph == PH_WIDTH) begin
							err = ERR_WIDTH_MISSING;
						end else if (end_r.ph == PH_HEIGHT) begin
							err = ERR_HEIGHT_MISSING;
						end else begin
							err = ERR_MAXVAL_MISSING;
						end
					end else begin
						err = ERR_NONE;
					end
				end
			end
		endcase

		if (err != ERR_NONE) begin
			res.kind = KIND_ERROR;
			res.final_pixel = 1'b0;
			res.data.pixel_value = '0;
			res.data.pixel_col = '0;
			res.data.pixel_row = '0;
			res.data.color_channel = '0;
			if (ph_c != PH_ERROR) begin
				ph_n = PH_ERROR;
				sticky_n = err;
			end
		end
		res.data.error_code = err;
		res.data.image_width = 13'(w_n);
		res.data.image_height = 13'(h_n);
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAGIC;
			cmt_q    <= 1'b0;
			tok_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
			chn_q    <= '0;
			sticky_q <= ERR_NONE;
		end else if (adv) begin
			phase_q  <= ph_n;
			cmt_q    <= cmt_n;
			tok_q    <= tok_n;
			width_q  <= w_n;
			height_q <= h_n;
			col_q    <= col_n;
			row_q    <= row_n;
			chn_q    <= chn_n;
			sticky_q <= sticky_n;
		end
	end

	// result buffer: main register plus skid entry
	assign pop = m_valid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (adv) begin
			if (m_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				m_valid_q <= 1'b1;
			end
		end else if (pop) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				m_res_q <= skid_res_q;
			end
		end else if (adv) begin
			if (m_valid_q && !pop) begin
				skid_res_q <= res;
			end else begin
				m_res_q <= res;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_res_q.data;
	assign m_axis_tuser  = m_res_q.kind;
	assign m_axis_tlast  = m_res_q.final_pixel;

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for ppm_p6_stream_parser_core: streams P6 files byte by byte
// and compares every result against a built-in parser model. Depends on ppmp6_pkg and
// the core RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ppmp6_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [7:0] data;
		bit         first;
		bit         last;
		bit         drain;
	} byte_req_t;

	typedef struct packed {
		kind_t       kind;
		err_t        err;
		logic [7:0]  pv;
		logic [11:0] col;
		logic [11:0] row;
		logic [1:0]  ch;
		logic        fin;
		logic [12:0] w;
		logic [12:0] h;
	} parse_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [M_TUSER_W-1:0] m_axis_tuser;
	logic m_axis_tlast;

	ppm_p6_stream_parser_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// parser model state
	phase_t     ps = PH_MAGIC;
	bit         cmt, tok_on, tok_bad, hdr_done;
	logic [1:0] mprog;
	int         acc, wd, ht, col, row;
	logic [1:0] chan;
	err_t       sticky = ERR_NONE;

	byte_req_t  byte_backlog[$];
	byte_req_t  file_q[$];
	parse_out_t pending_results[$];
	int n_sent, n_offered, n_results, n_fail, n_files, cyc, rx_cyc, rx_hold, rand_items;
	int kind_seen[5];

	function automatic bit is_ws(logic [7:0] b);
		return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
	endfunction

	function automatic void tok_clear();
		tok_on = 1'b0;
		tok_bad = 1'b0;
		mprog = MAGIC_NONE;
		acc = 0;
	endfunction

	function automatic void parse_reset();
		ps = PH_MAGIC;
		cmt = 1'b0;
		tok_clear();
		wd = 0;
		ht = 0;
		col = 0;
		row = 0;
		chan = 2'd0;
		sticky = ERR_NONE;
	endfunction

	function automatic void tok_add(logic [7:0] b);
		int v;
		tok_on = 1'b1;
		if (!tok_bad) begin
			if (ps == PH_MAGIC) begin
				if (mprog == MAGIC_NONE && b == CH_P) mprog = MAGIC_P;
				else if (mprog == MAGIC_P && b == CH_6) mprog = MAGIC_P6;
				else tok_bad = 1'b1;
			end else if (b >= CH_0 && b <= CH_9) begin
				v = acc * 10 + (int'(b) - int'(CH_0));
				acc = (v > int'(ACC_CAP)) ? int'(ACC_CAP) : v;
			end else begin
				tok_bad = 1'b1;
			end
		end
	endfunction

	function automatic err_t tok_end();
		err_t e;
		bit num_ok;
		e = ERR_NONE;
		num_ok = tok_on && !tok_bad && acc != 0;
		case (ps)
			PH_MAGIC: begin
				if (tok_on && !tok_bad && mprog == MAGIC_P6) ps = PH_WIDTH;
				else e = ERR_MAGIC;
			end
			PH_WIDTH: begin
				if (!tok_on) e = ERR_WIDTH_MISSING;
				else if (!num_ok) e = ERR_WIDTH_INVALID;
				else begin
					wd = acc;
					ps = PH_HEIGHT;
				end
			end
			PH_HEIGHT: begin
				if (!tok_on) e = ERR_HEIGHT_MISSING;
				else if (!num_ok) e = ERR_HEIGHT_INVALID;
				else begin
					ht = acc;
					ps = PH_MAXVAL;
				end
			end
			default: begin
				if (!tok_on) e = ERR_MAXVAL_MISSING;
				else if (!num_ok) e = ERR_MAXVAL_INVALID;
				else if (acc != int'(REQ_MAXVAL)) e = ERR_MAXVAL_NOT_255;
				else if (wd > DEF_MAX_WIDTH || ht > DEF_MAX_HEIGHT) e = ERR_TOO_LARGE;
				else begin
					ps = PH_PIXELS;
					col = 0;
					row = 0;
					chan = 2'd0;
					hdr_done = 1'b1;
				end
			end
		endcase
		tok_clear();
		return e;
	endfunction

	function automatic parse_out_t parse_byte(logic [7:0] b, bit first, bit last);
		parse_out_t r;
		err_t e;
		bit fin;
		r = '0;
		r.kind = KIND_HEADER;
		e = ERR_NONE;
		hdr_done = 1'b0;
		if (first) parse_reset();
		case (ps)
			PH_ERROR: begin
				r.kind = KIND_ERROR;
				e = sticky;
			end
			PH_DONE: r.kind = KIND_IGNORED;
			PH_PIXELS: begin
				if (cmt) begin
					if (b == CH_LF) cmt = 1'b0;
					if (last) e = ERR_TRUNCATED;
				end else begin
					fin = (col + 1 == wd) && (row + 1 == ht) && chan == CHAN_BLUE;
					if (last && !fin) begin
						e = ERR_TRUNCATED;
					end else begin
						r.kind = KIND_PIXEL;
						r.pv = b;
						r.col = col[11:0];
						r.row = row[11:0];
						r.ch = chan;
						r.fin = fin;
						if (fin) begin
							ps = PH_DONE;
						end else begin
							chan = chan + 2'd1;
							if (chan == 2'd3) begin
								chan = 2'd0;
								col++;
								if (col >= wd) begin
									col = 0;
									row++;
								end
							end
						end
					end
				end
			end
			default: begin
				if (cmt) begin
					if (b == CH_LF) cmt = 1'b0;
				end else if (!tok_on) begin
					if (b == CH_COMMENT) cmt = 1'b1;
					else if (!is_ws(b)) tok_add(b);
				end else if (is_ws(b)) begin
					e = tok_end();
				end else if (b == CH_COMMENT) begin
					cmt = 1'b1;
					e = tok_end();
				end else begin
					tok_add(b);
				end
				if (hdr_done) r.kind = KIND_COMPLETE;
				if (last && e == ERR_NONE) begin
					while (e == ERR_NONE && ps != PH_PIXELS) e = tok_end();
					if (e == ERR_NONE) e = ERR_TRUNCATED;
				end
			end
		endcase
		if (e != ERR_NONE) begin
			if (ps != PH_ERROR) begin
				ps = PH_ERROR;
				sticky = e;
			end
			r.kind = KIND_ERROR;
			r.pv = '0;
			r.col = '0;
			r.row = '0;
			r.ch = '0;
			r.fin = 1'b0;
		end
		r.err = e;
		r.w = wd[12:0];
		r.h = ht[12:0];
		return r;
	endfunction

	function automatic void put(logic [7:0] b);
		byte_req_t t;
		t.data = b;
		t.first = 1'b0;
		t.last = 1'b0;
		t.drain = 1'b0;
		file_q.insert(file_q.size(), t);
	endfunction

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++) put(s[i]);
	endfunction

	function automatic void put_pixels(int n);
		for (int i = 0; i < n; i++) put(8'($urandom_range(0, 255)));
	endfunction

	function automatic void put_sep();
		logic [7:0] ws_set[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
		logic [7:0] c;
		int n;
		n = $urandom_range(1, 3);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				put(CH_COMMENT);
				for (int k = $urandom_range(0, 6); k > 0; k--) begin
					c = 8'($urandom_range(0, 255));
					put(c == CH_LF ? CH_P : c);
				end
				put(CH_LF);
			end else begin
				put(ws_set[$urandom_range(0, 5)]);
			end
		end
	endfunction

	function automatic string num_text(int v);
		string s;
		s = $sformatf("%0d", v);
		if ($urandom_range(0, 9) == 0) s = {"00", s};
		return s;
	endfunction

	function automatic string bad_token();
		string opts[8] = '{"0", "000", "-3", "+4", "1x", "x9", "6P", "9-"};
		return opts[$urandom_range(0, 7)];
	endfunction

	// last_at < 0: file ends without an end-of-file mark
	function automatic void flush_file(bit with_first, int last_at, bit drain);
		byte_req_t t;
		if (last_at >= 0)
			while (file_q.size() > last_at + 1) void'(file_q.pop_back());
		foreach (file_q[i]) begin
			t = file_q[i];
			t.first = with_first && i == 0;
			t.last = (i == last_at);
			t.drain = drain && i == 0;
			byte_backlog.insert(byte_backlog.size(), t);
		end
		file_q.delete();
	endfunction

	function automatic void send_text(string s, bit with_last);
		put_str(s);
		flush_file(1'b1, with_last ? file_q.size() - 1 : -1, 1'b0);
	endfunction

	function automatic void gen_file(bit drain);
		string mg, wt, hs, mt;
		int mode, w, h, n_trail, last_at;
		mode = $urandom_range(0, 99);
		w = ($urandom_range(0, 49) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
		h = $urandom_range(1, 3);
		mg = "P6";
		wt = num_text(w);
		hs = num_text(h);
		mt = num_text(255);
		n_trail = 0;
		if (mode >= 66) begin
			case ($urandom_range(0, 6))
				0: begin
					string bad_magic[6] = '{"P5", "p6", "P", "P66", "P#6", "6P"};
					mg = bad_magic[$urandom_range(0, 5)];
				end
				1: wt = bad_token();
				2: hs = bad_token();
				3: mt = bad_token();
				4: mt = num_text($urandom_range(1, 65535));
				5: begin
					if ($urandom_range(0, 1)) wt = num_text($urandom_range(4097, 65535));
					else hs = "99999999";
				end
				default: begin
					put_pixels($urandom_range(1, 12));
					rand_items += file_q.size();
					flush_file($urandom_range(0, 9) != 0, file_q.size() - 1, drain);
					return;
				end
			endcase
		end
		put_str(mg);
		put_sep();
		put_str(wt);
		put_sep();
		put_str(hs);
		put_sep();
		put_str(mt);
		if ($urandom_range(0, 3) == 0) begin
			put(CH_COMMENT);
			put_str("px");
			put(CH_LF);
		end else begin
			put(($urandom_range(0, 1)) ? CH_SPACE : CH_LF);
		end
		put_pixels(w * h * 3);
		if ($urandom_range(0, 9) == 0) begin
			n_trail = $urandom_range(1, 3);
			put_pixels(n_trail);
		end
		rand_items += file_q.size() - n_trail;
		mode = $urandom_range(0, 99);
		if (mode < 15) last_at = $urandom_range(0, file_q.size() - 1);
		else if (mode < 23) last_at = -1;
		else last_at = file_q.size() - 1;
		flush_file($urandom_range(0, 19) != 0, last_at, drain);
	endfunction

	function automatic void build_stimulus();
		put_str("P6 1 1 255\n");
		put(8'h00);
		put(8'hFF);
		put(8'h80);
		put_str("zz");
		flush_file(1'b1, file_q.size() - 1, 1'b0);
		put_str("P6#c\n2 1 255#note\n");
		put_pixels(6);
		flush_file(1'b1, file_q.size() - 1, 1'b0);
		put_str("P6\t\013\014\r3\r2 0255 ");
		put_pixels(4);
		flush_file(1'b1, file_q.size() - 1, 1'b0);
		send_text("P5 1 1 255 ab", 1'b1);
		send_text("P6 0 1 255 ", 1'b1);
		send_text("P6 +1 1 255 ", 1'b1);
		send_text("P6 2", 1'b1);
		send_text("P6 1 #abc", 1'b1);
		send_text("P6 4097 1 255 x", 1'b1);
		send_text("P6 1 99999999 255 x", 1'b1);
		send_text("P6 1 1 256 x", 1'b1);
		send_text("P6 1 1 65535 x", 1'b1);
		send_text("P6 1 1 255", 1'b1);
		send_text("P6", 1'b1);
		send_text("#", 1'b1);
		send_text("P6 3 ", 1'b0);
		put_str("P6 4096 4096 255\n");
		put_pixels(4);
		flush_file(1'b1, file_q.size() - 1, 1'b0);
		put(8'hFF);
		flush_file(1'b1, 0, 1'b0);
		rand_items = 0;
		gen_file(1'b1);
		while (rand_items < 1300) gen_file($urandom_range(0, 29) == 0);
	endfunction

	// driver
	always @(posedge clk) begin : drv
		byte_req_t nx;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) n_sent++;
			if (byte_backlog.size() == 0
					|| ((n_offered < 400 || n_offered >= 800) && $urandom_range(0, 99) < 11)
					|| (byte_backlog[0].drain && n_sent != n_results)) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				nx = byte_backlog.pop_front();
				n_offered++;
				if (nx.first) n_files++;
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= nx.data;
				s_axis_tuser <= nx.first;
				s_axis_tlast <= nx.last;
			end
		end
	end

	// receiver with long hold-offs and a stall-free window
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			rx_cyc++;
			if (rx_cyc == 600 || rx_cyc == 2200) rx_hold = 150;
			if (rx_hold > 0) begin
				rx_hold--;
				m_axis_tready <= 1'b0;
			end else if (rx_cyc >= 1200 && rx_cyc < 1800) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= 11);
			end
		end
	end

	function automatic void cmp(string what, int want, int got);
		if (want != got) begin
			n_fail++;
			if (n_fail <= 50)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endfunction

	// monitor
	always @(posedge clk) begin : mon
		parse_out_t want;
		res_data_t got;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				pending_results.insert(pending_results.size(),
					parse_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast));
			if (m_axis_tvalid && m_axis_tready) begin
				n_results <= n_results + 1;
				if (m_axis_tuser < 3'd5) kind_seen[m_axis_tuser]++;
				if (pending_results.size() == 0) begin
					n_fail++;
					if (n_fail <= 50)
						$display("%0t: result with nothing expected, expected none, actual %h",
							$time, m_axis_tdata);
				end else begin
					want = pending_results.pop_front();
					got = res_data_t'(m_axis_tdata);
					cmp("kind", want.kind, m_axis_tuser);
					cmp("error_code", want.err, got.error_code);
					cmp("pixel_value", want.pv, got.pixel_value);
					cmp("pixel_col", want.col, got.pixel_col);
					cmp("pixel_row", want.row, got.pixel_row);
					cmp("color_channel", want.ch, got.color_channel);
					cmp("final_pixel", want.fin, m_axis_tlast);
					cmp("image_width", want.w, got.image_width);
					cmp("image_height", want.h, got.image_height);
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("ppm_p6_stream_parser_core test failed");
			$finish;
		end
	end

	initial begin
		parse_reset();
		build_stimulus();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		do @(negedge clk); while (byte_backlog.size() != 0 || s_axis_tvalid);
		do @(negedge clk); while (n_results != n_sent);
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0) begin
			n_fail++;
			$display("%0t: %0d results never arrived", $time, pending_results.size());
		end
		$display("Streamed %0d bytes in %0d files: %0d header, %0d pixel, %0d error,",
			n_sent, n_files, kind_seen[0], kind_seen[1], kind_seen[2]);
		$display("  %0d ignored and %0d header-complete results, %0d mismatches.",
			kind_seen[3], kind_seen[4], n_fail);
		if (n_fail == 0)
			$display("ppm_p6_stream_parser_core test passed");
		else
			$display("ppm_p6_stream_parser_core test failed");
		$finish;
	end

endmodule
